[sv/oqksd_pkg.sv]
// Shared types and codes for the ordered key queue.
package oqksd_pkg;

    // Fixed port field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 16;
    localparam int HND_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch command and register the key match vector
        logic commit;   // apply the update and load the result register
    } t_dp_ctl;

endpackage

[sv/oqksd_ctrl.sv]
// Controller state machine for the ordered key queue.
module oqksd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output oqksd_pkg::t_dp_ctl o_ctl
);
    import oqksd_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_UPDATE = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_ctl.capture = 1'b0;
        o_ctl.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    o_ctl.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/oqksd_dp.sv]
// Datapath for the ordered key queue: entry cells, match logic, result register.
module oqksd_dp #(
    parameter int DEPTH        = 16,
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  oqksd_pkg::t_dp_ctl            i_ctl,
    input  logic [oqksd_pkg::CMD_W-1:0]   i_command,
    input  logic [oqksd_pkg::KEY_W-1:0]   i_key,
    input  logic [oqksd_pkg::HND_W-1:0]   i_handle,
    output logic [oqksd_pkg::STATUS_W-1:0] o_status,
    output logic [oqksd_pkg::HND_W-1:0]   o_found_handle,
    output logic [oqksd_pkg::OCC_W-1:0]   o_occupancy
);
    import oqksd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // entry cells, oldest at index 0
    logic [KEY_WIDTH-1:0]    r_keys [DEPTH];
    logic [HANDLE_WIDTH-1:0] r_hnds [DEPTH];
    logic [KEY_WIDTH-1:0]    up_key [DEPTH];
    logic [HANDLE_WIDTH-1:0] up_hnd [DEPTH];
    logic [CW-1:0]           r_count, n_count;

    // captured command
    logic [CMD_W-1:0]        r_cmd;
    logic [KEY_WIDTH-1:0]    r_key;
    logic [HANDLE_WIDTH-1:0] r_hnd;
    logic [DEPTH-1:0]        r_match;

    logic [31:0]             key_ext;
    logic [31:0]             hnd_ext;
    logic [KEY_WIDTH-1:0]    key_in;
    logic [HANDLE_WIDTH-1:0] hnd_in;
    logic [DEPTH-1:0]        match_now;
    logic [DEPTH-1:0]        one;
    logic [DEPTH-1:0]        first;
    logic [DEPTH-1:0]        from_first;
    logic                    any_match;
    logic                    full;
    logic                    ins_we;
    logic                    rem_we;
    logic [HANDLE_WIDTH-1:0] sel_hnd;
    logic [32:0]             sel_ext;
    logic [32:0]             occ_ext;

    // result register
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [HND_W-1:0]        r_found, n_found;

    assign key_ext = {16'd0, i_key};
    assign hnd_ext = {16'd0, i_handle};
    assign key_in  = key_ext[KEY_WIDTH-1:0];
    assign hnd_in  = hnd_ext[HANDLE_WIDTH-1:0];

    // parallel compare against every live cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match_now[i] = (CW'(i) < r_count) && (r_keys[i] == key_in);
        end
    end

    // isolate the oldest match, and mark it plus every younger cell
    assign one        = {{(DEPTH-1){1'b0}}, 1'b1};
    assign first      = r_match & (~r_match + one);
    assign from_first = ~(first - one);
    assign any_match  = |r_match;
    assign full       = (r_count == CW'(DEPTH));
    assign ins_we     = i_ctl.commit && (r_cmd == CMD_INSERT) && !full;
    assign rem_we     = i_ctl.commit && (r_cmd == CMD_REMOVE) && any_match;

    always_comb begin
        sel_hnd = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_hnd = sel_hnd | (r_hnds[i] & {HANDLE_WIDTH{first[i]}});
        end
    end

    assign sel_ext = {{(33-HANDLE_WIDTH){1'b0}}, sel_hnd};

    always_comb begin
        n_status = ST_NOT_FOUND;
        n_found  = '0;
        n_count  = r_count;
        unique case (r_cmd) inside
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_DONE;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_REMOVE, CMD_SEARCH: begin
                if (any_match) begin
                    n_status = ST_DONE;
                    n_found  = sel_ext[HND_W-1:0];
                    if (r_cmd == CMD_REMOVE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: n_status = ST_NOT_FOUND;
        endcase
    end

    // each cell loads the tail entry or shifts down from its younger neighbour
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g < DEPTH - 1) begin : g_up
            assign up_key[g] = r_keys[g+1];
            assign up_hnd[g] = r_hnds[g+1];
        end else begin : g_top
            assign up_key[g] = r_keys[g];
            assign up_hnd[g] = r_hnds[g];
        end

        always_ff @(posedge i_clk) begin
            if (ins_we && (r_count == CW'(g))) begin
                r_keys[g] <= r_key;
                r_hnds[g] <= r_hnd;
            end else if (rem_we && from_first[g]) begin
                r_keys[g] <= up_key[g];
                r_hnds[g] <= up_hnd[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_command;
            r_key   <= key_in;
            r_hnd   <= hnd_in;
            r_match <= match_now;
        end
        if (i_ctl.commit) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.commit) begin
            r_count <= n_count;
        end
    end

    assign occ_ext        = {{(33-CW){1'b0}}, r_count};
    assign o_status       = r_status;
    assign o_found_handle = r_found;
    assign o_occupancy    = occ_ext[OCC_W-1:0];

endmodule

[sv/ordered_queue_key_search_delete.sv]
// Top level of the ordered key queue with search and remove by key.
//
// Holds an ordered queue of up to DEPTH entries, each a key and a handle, in
// a row of register cells with the oldest entry at cell 0. Each command runs
// as a compare step and then an update step: on the transfer of the input
// the key is compared against all live cells at once and the match vector
// is registered; then, once the output register is free, the oldest match
// is picked, the cells are updated (append at the tail, or shift the younger
// entries down one place to close the gap) and the result is loaded into
// the output register. A new command is taken as soon as the previous one has
// been loaded into the output register, even while that result still waits
// to be taken. A result is held back only while the
// output register is still occupied. Insert on a full queue reports full,
// remove or search with no match (or on an empty queue, or with the unused
// command code) reports not found with a zero handle; occupancy is the
// number of entries held after the command, kept to five bits. Keys and
// handles are used to KEY_WIDTH and HANDLE_WIDTH bits; duplicate keys are
// allowed and remove and search always act on the oldest.
module ordered_queue_key_search_delete #(
    parameter int DEPTH        = 16,
    parameter int KEY_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [oqksd_pkg::CMD_W-1:0]    i_command,
    input  logic [oqksd_pkg::KEY_W-1:0]    i_key,
    input  logic [oqksd_pkg::HND_W-1:0]    i_handle,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [oqksd_pkg::STATUS_W-1:0] o_status,
    output logic [oqksd_pkg::HND_W-1:0]    o_found_handle,
    output logic [oqksd_pkg::OCC_W-1:0]    o_occupancy
);
    import oqksd_pkg::*;

    t_dp_ctl dp_ctl;

    // sequence capture and commit, own the result valid flag
    oqksd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (dp_ctl)
    );

    // hold the entry cells, match and shift logic and the result payload
    oqksd_dp #(
        .DEPTH        (DEPTH),
        .KEY_WIDTH    (KEY_WIDTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (dp_ctl),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_handle       (i_handle),
        .o_status       (o_status),
        .o_found_handle (o_found_handle),
        .o_occupancy    (o_occupancy)
    );

endmodule
